@@ sv/ved_pkg.sv @@
// Shared types and constants for the Voronoi edge distance block.
package ved_pkg;

	localparam int PIX_W      = 11;
	localparam int IDX_W      = 6;
	localparam int CNT_W      = 7;
	localparam int BAND_W     = 12;
	localparam int OUT_W      = 20;
	localparam int QUOT_W     = 41;
	localparam int DIV_STEPS  = 41;
	localparam int SQRT_STEPS = 20;
	localparam int STEP_W     = 6;
	localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

	localparam logic OPC_LOAD  = 1'b0;
	localparam logic OPC_PIXEL = 1'b1;

	localparam logic REG_SITE_COUNT = 1'b0;
	localparam logic REG_EDGE_BAND  = 1'b1;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_N_RD,
		ST_N_DIFF,
		ST_N_SQ,
		ST_N_CMP,
		ST_A_RD,
		ST_A_LATCH,
		ST_B_RD,
		ST_B_DIFF,
		ST_B_MUL1,
		ST_B_MUL2,
		ST_B_MUL3,
		ST_B_MUL4,
		ST_B_MUL5,
		ST_B_CMP,
		ST_DIV,
		ST_SQRT,
		ST_UPD,
		ST_OUT
	} state_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_PIX,
		OP_N_DIFF,
		OP_N_SQ,
		OP_N_CMP,
		OP_A_LATCH,
		OP_B_DIFF,
		OP_B_MUL1,
		OP_B_MUL2,
		OP_B_MUL3,
		OP_B_MUL4,
		OP_B_MUL5,
		OP_B_CMP,
		OP_DIV,
		OP_SQRT,
		OP_UPD
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic pair_equal;
	} dp_stat_t;

endpackage

@@ sv/ved_ram.sv @@
// Generic RAM with one write port and one registered read port.
module ved_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ sv/ved_dp.sv @@
// Datapath: nearest-site search, bisector distance, divider and square root.
module ved_dp #(
	parameter int MAX_SITES  = 64,
	parameter int COORD_BITS = 12
) (
	input  logic                          clk,
	input  ved_pkg::dp_cmd_t              cmd,
	input  logic [$clog2(MAX_SITES)-1:0]  cur_idx,
	input  logic [2*COORD_BITS-1:0]       site_data,
	input  logic [ved_pkg::PIX_W-1:0]     pixel_x,
	input  logic [ved_pkg::PIX_W-1:0]     pixel_y,
	input  logic [ved_pkg::BAND_W-1:0]    edge_band,
	output logic [$clog2(MAX_SITES)-1:0]  best_idx,
	output ved_pkg::dp_stat_t             stat,
	output logic [ved_pkg::OUT_W-1:0]     edge_distance
);
	import ved_pkg::*;

	localparam int AW   = $clog2(MAX_SITES);
	localparam int CB   = COORD_BITS;
	localparam int DXW  = ((CB > PIX_W + 1) ? CB : PIX_W + 1) + 1;
	localparam int DSW  = 2 * DXW + 1;
	localparam int AB_W = CB + 1;
	localparam int SUMW = CB + 2;
	localparam int PW   = 2 * CB + 3;
	localparam int QW   = CB + PIX_W + 2;
	localparam int TW   = (PW > QW) ? PW : QW;
	localparam int NUMW = TW + 2;
	localparam int SW   = 2 * CB + 2;
	localparam int N2W  = 2 * NUMW;
	localparam int BSW  = 2 * BAND_W + SW;
	localparam int CMW  = (N2W > BSW) ? N2W : BSW;
	localparam int MW   = N2W + 8;
	localparam int RW   = 2 * SQRT_STEPS + 2;

	// Pixel and nearest-site search
	logic signed [PIX_W:0]     px_q, py_q;
	logic signed [DXW-1:0]     dx_q, dy_q;
	logic [2*DXW-1:0]          sqx_q, sqy_q;
	logic [DSW-1:0]            bestd_q;
	logic                      best_vld_q;
	logic [AW-1:0]             best_q;
	logic [2*BAND_W-1:0]       band2_q;

	// Bisector terms
	logic signed [CB-1:0]      ax_q, ay_q;
	logic signed [AB_W-1:0]    a_q, b_q;
	logic signed [SUMW-1:0]    sa_q, sb_q;
	logic                      eq_q;
	logic signed [PW-1:0]      pa_q, pb_q;
	logic signed [QW-1:0]      qa_q, qb_q;
	logic signed [NUMW-1:0]    c_q, num_q;
	logic signed [SW-1:0]      sqa_q, sqb_q;
	logic [SW-1:0]             s_q;
	logic [NUMW-1:0]           n_q;
	logic [N2W-1:0]            n2_q;
	logic [BSW-1:0]            bs_q;

	// Divider, square root and running result
	logic [SW-1:0]             r_q;
	logic [QUOT_W-1:0]         low_q, quot_q;
	logic                      sat_q;
	logic [RW-1:0]             rem_q;
	logic [SQRT_STEPS-1:0]     root_q;
	logic [OUT_W-1:0]          result_q;
	logic                      in_band_q;

	logic signed [CB-1:0]      bx, by;
	logic signed [DSW-1:0]     d_sum;
	logic signed [PW-1:0]      pa_half, pb_half;
	logic signed [NUMW-1:0]    num_sum;
	logic [MW-1:0]             m_full;
	logic [MW-1:0]             m_hi;
	logic                      sat0;
	logic [SW:0]               r_trial;
	logic                      qbit;
	logic [RW+1:0]             rem_trial, root_trial;
	logic [OUT_W-1:0]          q_cand;

	assign bx = site_data[2*CB-1:CB];
	assign by = site_data[CB-1:0];

	assign d_sum   = DSW'(sqx_q) + DSW'(sqy_q);
	assign pa_half = (pa_q + $signed(PW'(pa_q[PW-1]))) >>> 1;
	assign pb_half = (pb_q + $signed(PW'(pb_q[PW-1]))) >>> 1;
	assign num_sum = NUMW'(qa_q) + NUMW'(qb_q) + c_q;

	assign m_full = {n2_q, 8'd0};
	assign m_hi   = m_full >> QUOT_W;
	assign sat0   = m_hi >= MW'(s_q);

	assign r_trial = {r_q, low_q[QUOT_W-1]};
	assign qbit    = r_trial >= {1'b0, s_q};

	assign rem_trial  = {rem_q, quot_q[QUOT_W-2:QUOT_W-3]};
	assign root_trial = (RW+2)'({root_q, 2'b01});

	assign q_cand = (sat_q || quot_q[QUOT_W-1]) ? OUT_MAX : OUT_W'(root_q);

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_PIX: begin
				px_q       <= $signed({1'b0, pixel_x});
				py_q       <= $signed({1'b0, pixel_y});
				band2_q    <= (2*BAND_W)'(edge_band) * (2*BAND_W)'(edge_band);
				best_vld_q <= 1'b0;
				best_q     <= '0;
				result_q   <= OUT_MAX;
				in_band_q  <= 1'b0;
			end
			OP_N_DIFF: begin
				dx_q <= DXW'(px_q) - DXW'(bx);
				dy_q <= DXW'(py_q) - DXW'(by);
			end
			OP_N_SQ: begin
				sqx_q <= unsigned'((2*DXW)'(dx_q) * (2*DXW)'(dx_q));
				sqy_q <= unsigned'((2*DXW)'(dy_q) * (2*DXW)'(dy_q));
			end
			OP_N_CMP: begin
				if (!best_vld_q || unsigned'(d_sum) < bestd_q) begin
					bestd_q    <= unsigned'(d_sum);
					best_q     <= cur_idx;
					best_vld_q <= 1'b1;
				end
			end
			OP_A_LATCH: begin
				ax_q <= bx;
				ay_q <= by;
			end
			OP_B_DIFF: begin
				a_q  <= AB_W'(ax_q) - AB_W'(bx);
				b_q  <= AB_W'(ay_q) - AB_W'(by);
				sa_q <= -SUMW'(ax_q) - SUMW'(bx);
				sb_q <= -SUMW'(ay_q) - SUMW'(by);
				eq_q <= (ax_q == bx) && (ay_q == by);
			end
			OP_B_MUL1: begin
				pa_q <= PW'(a_q) * PW'(sa_q);
				pb_q <= PW'(b_q) * PW'(sb_q);
			end
			OP_B_MUL2: begin
				c_q  <= NUMW'(pa_half) + NUMW'(pb_half);
				qa_q <= QW'(a_q) * QW'(px_q);
				qb_q <= QW'(b_q) * QW'(py_q);
			end
			OP_B_MUL3: begin
				num_q <= num_sum;
				sqa_q <= SW'(a_q) * SW'(a_q);
				sqb_q <= SW'(b_q) * SW'(b_q);
			end
			OP_B_MUL4: begin
				s_q <= unsigned'(sqa_q) + unsigned'(sqb_q);
				n_q <= num_q[NUMW-1] ? unsigned'(-num_q) : unsigned'(num_q);
			end
			OP_B_MUL5: begin
				n2_q <= N2W'(n_q) * N2W'(n_q);
				bs_q <= BSW'(band2_q) * BSW'(s_q);
			end
			OP_B_CMP: begin
				if (CMW'(n2_q) <= CMW'(bs_q)) begin
					in_band_q <= 1'b1;
				end
				sat_q  <= sat0;
				r_q    <= sat0 ? '0 : SW'(m_hi);
				low_q  <= m_full[QUOT_W-1:0];
				quot_q <= '0;
				rem_q  <= '0;
				root_q <= '0;
			end
			OP_DIV: begin
				r_q    <= qbit ? SW'(r_trial - {1'b0, s_q}) : SW'(r_trial);
				low_q  <= {low_q[QUOT_W-2:0], 1'b0};
				quot_q <= {quot_q[QUOT_W-2:0], qbit};
			end
			OP_SQRT: begin
				// Bit 40 of the quotient stays put; it marks saturation.
				quot_q <= {quot_q[QUOT_W-1], quot_q[QUOT_W-4:0], 2'b00};
				if (rem_trial >= root_trial) begin
					rem_q  <= RW'(rem_trial - root_trial);
					root_q <= {root_q[SQRT_STEPS-2:0], 1'b1};
				end else begin
					rem_q  <= RW'(rem_trial);
					root_q <= {root_q[SQRT_STEPS-2:0], 1'b0};
				end
			end
			OP_UPD: begin
				if (q_cand < result_q) begin
					result_q <= q_cand;
				end
			end
			default: begin
			end
		endcase
	end

	assign best_idx        = best_q;
	assign stat.pair_equal = eq_q;
	assign edge_distance   = in_band_q ? '0 : result_q;

endmodule

@@ sv/ved_ctrl.sv @@
// Controller state machine that sequences the site walks of one pixel.
module ved_ctrl #(
	parameter int MAX_SITES = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          opcode,
	input  logic [ved_pkg::CNT_W-1:0]     site_count,
	input  logic [$clog2(MAX_SITES)-1:0]  best_idx,
	input  ved_pkg::dp_stat_t             stat,
	output logic                          busy,
	output logic                          done,
	output ved_pkg::dp_cmd_t              cmd,
	output logic [$clog2(MAX_SITES)-1:0]  rd_addr,
	output logic [$clog2(MAX_SITES)-1:0]  cur_idx
);
	import ved_pkg::*;

	localparam int AW = $clog2(MAX_SITES);

	state_t            state_q, state_nxt;
	logic [AW-1:0]     j_q;
	logic [STEP_W-1:0] step_q;
	logic [AW-1:0]     last_idx;
	logic              is_last;
	int                eff_count;

	always_comb begin
		if (site_count == '0) begin
			eff_count = 1;
		end else if (int'(site_count) > MAX_SITES) begin
			eff_count = MAX_SITES;
		end else begin
			eff_count = int'(site_count);
		end
	end

	assign last_idx = AW'(eff_count - 1);
	assign is_last  = j_q == last_idx;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE:    if (start && opcode == OPC_PIXEL) state_nxt = ST_N_RD;
			ST_N_RD:    state_nxt = ST_N_DIFF;
			ST_N_DIFF:  state_nxt = ST_N_SQ;
			ST_N_SQ:    state_nxt = ST_N_CMP;
			ST_N_CMP:   state_nxt = is_last ? ST_A_RD : ST_N_RD;
			ST_A_RD:    state_nxt = ST_A_LATCH;
			ST_A_LATCH: state_nxt = ST_B_RD;
			ST_B_RD:    state_nxt = ST_B_DIFF;
			ST_B_DIFF:  state_nxt = ST_B_MUL1;
			ST_B_MUL1: begin
				if (stat.pair_equal) begin
					state_nxt = is_last ? ST_OUT : ST_B_RD;
				end else begin
					state_nxt = ST_B_MUL2;
				end
			end
			ST_B_MUL2:  state_nxt = ST_B_MUL3;
			ST_B_MUL3:  state_nxt = ST_B_MUL4;
			ST_B_MUL4:  state_nxt = ST_B_MUL5;
			ST_B_MUL5:  state_nxt = ST_B_CMP;
			ST_B_CMP:   state_nxt = ST_DIV;
			ST_DIV:     if (step_q == STEP_W'(DIV_STEPS - 1)) state_nxt = ST_SQRT;
			ST_SQRT:    if (step_q == STEP_W'(SQRT_STEPS - 1)) state_nxt = ST_UPD;
			ST_UPD:     state_nxt = is_last ? ST_OUT : ST_B_RD;
			ST_OUT:     state_nxt = ST_IDLE;
			default:    state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.op  = OP_NONE;
		rd_addr = j_q;
		unique case (state_q)
			ST_IDLE:    if (start && opcode == OPC_PIXEL) cmd.op = OP_PIX;
			ST_N_DIFF:  cmd.op = OP_N_DIFF;
			ST_N_SQ:    cmd.op = OP_N_SQ;
			ST_N_CMP:   cmd.op = OP_N_CMP;
			ST_A_RD:    rd_addr = best_idx;
			ST_A_LATCH: cmd.op = OP_A_LATCH;
			ST_B_DIFF:  cmd.op = OP_B_DIFF;
			ST_B_MUL1:  cmd.op = OP_B_MUL1;
			ST_B_MUL2:  cmd.op = OP_B_MUL2;
			ST_B_MUL3:  cmd.op = OP_B_MUL3;
			ST_B_MUL4:  cmd.op = OP_B_MUL4;
			ST_B_MUL5:  cmd.op = OP_B_MUL5;
			ST_B_CMP:   cmd.op = OP_B_CMP;
			ST_DIV:     cmd.op = OP_DIV;
			ST_SQRT:    cmd.op = OP_SQRT;
			ST_UPD:     cmd.op = OP_UPD;
			default:    cmd.op = OP_NONE;
		endcase
	end

	assign busy    = state_q != ST_IDLE;
	assign done    = state_q == ST_OUT;
	assign cur_idx = j_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			j_q     <= '0;
			step_q  <= '0;
		end else begin
			state_q <= state_nxt;
			case (state_q)
				ST_IDLE:  j_q <= '0;
				ST_N_CMP: j_q <= is_last ? '0 : j_q + 1'b1;
				ST_B_MUL1: begin
					if (stat.pair_equal && !is_last) begin
						j_q <= j_q + 1'b1;
					end
				end
				ST_UPD:   if (!is_last) j_q <= j_q + 1'b1;
				default: begin
				end
			endcase
			if (state_q == ST_B_CMP || state_nxt != state_q) begin
				step_q <= '0;
			end else begin
				step_q <= step_q + 1'b1;
			end
		end
	end

endmodule

@@ sv/voronoi_edge_distance_top.sv @@
// Top level of the Voronoi edge distance block: register port, site table, control, datapath.
// A load transfer writes the site table and gives no result; busy stays low.
// A pixel transfer walks the n sites in use twice: once for the nearest search, then a fetch of
// the nearest site, then per other site a fetch, differences, the multiply steps, a compare, a
// divider, a square root and an update, or only a fetch, differences and the first multiply
// step per equal site, and last a result state; done marks the one-cycle result.
// Reset sets site_count to 1, edge_band to 0 and the controller to idle.
module voronoi_edge_distance_top #(
	parameter int MAX_SITES  = 64,
	parameter int COORD_BITS = 12
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Command channel
	input  logic                          start,
	output logic                          busy,
	input  logic                          opcode,
	input  logic [ved_pkg::IDX_W-1:0]     site_index,
	input  logic signed [COORD_BITS-1:0]  site_x,
	input  logic signed [COORD_BITS-1:0]  site_y,
	input  logic [ved_pkg::PIX_W-1:0]     pixel_x,
	input  logic [ved_pkg::PIX_W-1:0]     pixel_y,
	// Result channel
	output logic                          done,
	output logic [ved_pkg::OUT_W-1:0]     edge_distance,
	// Register port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [2:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import ved_pkg::*;

	localparam int AW = $clog2(MAX_SITES);

	logic [CNT_W-1:0]      site_count_q;
	logic [BAND_W-1:0]     edge_band_q;
	logic                  cfg_wr;
	logic                  load_wr;
	logic [AW-1:0]         rd_addr;
	logic [AW-1:0]         cur_idx;
	logic [AW-1:0]         best_idx;
	logic [2*COORD_BITS-1:0] site_data;
	dp_cmd_t               cmd;
	dp_stat_t              stat;

	// Register writes complete in the access cycle; bit 2 of the address picks the register.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			site_count_q <= CNT_W'(1);
			edge_band_q  <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_SITE_COUNT: site_count_q <= pwdata[CNT_W-1:0];
				REG_EDGE_BAND:  edge_band_q  <= pwdata[BAND_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_SITE_COUNT: prdata = 32'(site_count_q);
			REG_EDGE_BAND:  prdata = 32'(edge_band_q);
			default:        prdata = '0;
		endcase
	end

	// A load transfer writes the table directly; slots past the table size are dropped.
	assign load_wr = start && !busy && opcode == OPC_LOAD && int'(site_index) < MAX_SITES;

	ved_ram #(
		.WIDTH (2 * COORD_BITS),
		.DEPTH (MAX_SITES)
	) u_sites (
		.clk   (clk),
		.we    (load_wr),
		.waddr (AW'(site_index)),
		.wdata ({site_x, site_y}),
		.raddr (rd_addr),
		.rdata (site_data)
	);

	ved_ctrl #(
		.MAX_SITES (MAX_SITES)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.opcode     (opcode),
		.site_count (site_count_q),
		.best_idx   (best_idx),
		.stat       (stat),
		.busy       (busy),
		.done       (done),
		.cmd        (cmd),
		.rd_addr    (rd_addr),
		.cur_idx    (cur_idx)
	);

	ved_dp #(
		.MAX_SITES  (MAX_SITES),
		.COORD_BITS (COORD_BITS)
	) u_dp (
		.clk           (clk),
		.cmd           (cmd),
		.cur_idx       (cur_idx),
		.site_data     (site_data),
		.pixel_x       (pixel_x),
		.pixel_y       (pixel_y),
		.edge_band     (edge_band_q),
		.best_idx      (best_idx),
		.stat          (stat),
		.edge_distance (edge_distance)
	);

endmodule
